[src/h2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package h2d_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNTB_W  = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned CFG_IW  = 3;

  // Divider sizing: the quotient is below the bin count, so it fits in the
  // bin count width; the dividend is bin count times a 32-bit offset.
  localparam int unsigned QW      = CNTB_W;
  localparam int unsigned NUMW    = CNTB_W + VAL_W;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WFILL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_X_LOW   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_X_HIGH  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_X_COUNT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_Y_LOW   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_Y_HIGH  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_Y_COUNT = 3'd5;

  // Plain fill adds 1.0 in Q16.16.
  localparam logic signed [SUM_W-1:0] ONE_Q16 = 48'sd65536;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] x_sample;
    logic signed [VAL_W-1:0] y_sample;
    logic signed [VAL_W-1:0] weight;
    logic [IDX_W-1:0]        read_x_bin;
    logic [IDX_W-1:0]        read_y_bin;
  } h2d_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] bin_value;
    logic                    hit;
    logic [IDX_W-1:0]        x_bin;
    logic [IDX_W-1:0]        y_bin;
    logic [TOT_W-1:0]        x_over_count;
    logic [TOT_W-1:0]        x_under_count;
    logic [TOT_W-1:0]        y_over_count;
    logic [TOT_W-1:0]        y_under_count;
  } h2d_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic mul_x;
    logic mul_y;
    logic div_start;
    logic cap_x;
    logic cap_y;
    logic rd;
    logic finish;
  } h2d_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic fill;
  } h2d_stat_t;

endpackage

`default_nettype wire

[src/h2d_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module h2d_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/h2d_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module h2d_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [h2d_pkg::NUMW-1:0]  dividend,
  input  wire logic [h2d_pkg::VAL_W-1:0] divisor,
  output logic      [h2d_pkg::QW-1:0]    quotient,
  output logic                           done
);

  localparam int unsigned NW = h2d_pkg::NUMW;
  localparam int unsigned QN = h2d_pkg::QW;
  localparam int unsigned CW = $clog2(QN);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          run;
  logic          ge;

  assign ge = (rem >= dsh);

  // Restoring division, one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dsh      <= NW'(divisor) << (QN - 1);
        quotient <= '0;
        cnt      <= '0;
        run      <= 1'b1;
      end else if (run) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[QN-2:0], ge};
        dsh      <= dsh >> 1;
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(QN - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/h2d_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module h2d_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire h2d_pkg::h2d_stat_t  stat,
  output h2d_pkg::h2d_cmd_t        cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_XMUL  = 4'd2;
  localparam logic [3:0] S_XDS   = 4'd3;
  localparam logic [3:0] S_XDIV  = 4'd4;
  localparam logic [3:0] S_YMUL  = 4'd5;
  localparam logic [3:0] S_YDS   = 4'd6;
  localparam logic [3:0] S_YDIV  = 4'd7;
  localparam logic [3:0] S_ADDR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_XMUL;
        end
      end
      S_XMUL: begin
        cmd.mul_x  = 1'b1;
        state_next = stat.fill ? S_XDS : S_ADDR;
      end
      S_XDS: begin
        cmd.div_start = 1'b1;
        state_next    = S_XDIV;
      end
      S_XDIV: begin
        if (stat.div_done) begin
          cmd.cap_x  = 1'b1;
          state_next = S_YMUL;
        end
      end
      S_YMUL: begin
        cmd.mul_y  = 1'b1;
        state_next = S_YDS;
      end
      S_YDS: begin
        cmd.div_start = 1'b1;
        state_next    = S_YDIV;
      end
      S_YDIV: begin
        if (stat.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/h2d_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module h2d_datapath #(
  parameter int unsigned MAX_X_BINS = 64,
  parameter int unsigned MAX_Y_BINS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [h2d_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [h2d_pkg::VAL_W-1:0]  cfg_data,
  input  wire h2d_pkg::h2d_in_t           item,
  input  wire h2d_pkg::h2d_cmd_t          cmd,
  output h2d_pkg::h2d_stat_t              stat,
  output h2d_pkg::h2d_out_t               result,
  output logic                            done
);

  localparam int unsigned DEPTH = MAX_X_BINS * MAX_Y_BINS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VW    = h2d_pkg::VAL_W;
  localparam int unsigned NBW   = h2d_pkg::CNTB_W;
  localparam int unsigned SW    = h2d_pkg::SUM_W;
  localparam int unsigned TW    = h2d_pkg::TOT_W;
  localparam int unsigned IW    = h2d_pkg::IDX_W;

  // Configuration registers.
  logic signed [VW-1:0] x_low, x_high, y_low, y_high;
  logic [NBW-1:0]       x_bin_count, y_bin_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low       <= '0;
      x_high      <= 32'sd4194304;
      x_bin_count <= 7'd64;
      y_low       <= '0;
      y_high      <= 32'sd4194304;
      y_bin_count <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h2d_pkg::REG_X_LOW:   x_low       <= cfg_data;
        h2d_pkg::REG_X_HIGH:  x_high      <= cfg_data;
        h2d_pkg::REG_X_COUNT: x_bin_count <= cfg_data[NBW-1:0];
        h2d_pkg::REG_Y_LOW:   y_low       <= cfg_data;
        h2d_pkg::REG_Y_HIGH:  y_high      <= cfg_data;
        h2d_pkg::REG_Y_COUNT: y_bin_count <= cfg_data[NBW-1:0];
        default: ;
      endcase
    end
  end

  // Bin counts in use: zero means one, anything above the store limit clips.
  logic [NBW-1:0] nx, ny;

  always_comb begin
    if (x_bin_count == '0) nx = NBW'(1);
    else if (32'(x_bin_count) > MAX_X_BINS) nx = NBW'(MAX_X_BINS);
    else nx = x_bin_count;
    if (y_bin_count == '0) ny = NBW'(1);
    else if (32'(y_bin_count) > MAX_Y_BINS) ny = NBW'(MAX_Y_BINS);
    else ny = y_bin_count;
  end

  // Item captured on accept.
  h2d_pkg::h2d_in_t it;

  always_ff @(posedge clk) begin
    if (cmd.load) it <= item;
  end

  logic is_fill;
  assign is_fill = (it.cmd == h2d_pkg::CMD_FILL) || (it.cmd == h2d_pkg::CMD_WFILL);

  // Range tests; the overflow test wins when the edges are reversed.
  logic x_over, x_under, y_over, y_under, x_ok, y_ok;

  assign x_over  = (it.x_sample >= x_high);
  assign x_under = !x_over && (it.x_sample < x_low);
  assign y_over  = (it.y_sample >= y_high);
  assign y_under = !y_over && (it.y_sample < y_low);
  assign x_ok    = !x_over && !x_under;
  assign y_ok    = !y_over && !y_under;

  // Offsets and spans; both fit in 32 unsigned bits whenever the axis is in range.
  logic [VW:0] x_off, x_span, y_off, y_span;

  assign x_off  = {it.x_sample[VW-1], it.x_sample} - {x_low[VW-1], x_low};
  assign x_span = {x_high[VW-1], x_high} - {x_low[VW-1], x_low};
  assign y_off  = {it.y_sample[VW-1], it.y_sample} - {y_low[VW-1], y_low};
  assign y_span = {y_high[VW-1], y_high} - {y_low[VW-1], y_low};

  // Scale the offset by the bin count, then divide by the span.
  logic [h2d_pkg::NUMW-1:0] prod;
  logic [VW-1:0]            divisor;
  logic [h2d_pkg::QW-1:0]   quotient;
  logic                     div_done;

  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      prod    <= h2d_pkg::NUMW'(nx) * h2d_pkg::NUMW'(x_off[VW-1:0]);
      divisor <= x_span[VW-1:0];
    end else if (cmd.mul_y) begin
      prod    <= h2d_pkg::NUMW'(ny) * h2d_pkg::NUMW'(y_off[VW-1:0]);
      divisor <= y_span[VW-1:0];
    end
  end

  h2d_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  logic [NBW-1:0] bx, by;

  always_ff @(posedge clk) begin
    if (cmd.cap_x) bx <= quotient;
    if (cmd.cap_y) by <= quotient;
  end

  // Bin coordinates and store address for the current command.
  logic [NBW-1:0] ax, ay;
  logic [31:0]    addr_wide;
  logic [AW-1:0]  addr;
  logic           rd_ok;

  assign ax        = is_fill ? bx : NBW'(it.read_x_bin);
  assign ay        = is_fill ? by : NBW'(it.read_y_bin);
  assign addr_wide = 32'(ax) * 32'(MAX_Y_BINS) + 32'(ay);
  assign addr      = addr_wide[AW-1:0];
  assign rd_ok     = (it.read_x_bin < IW'(nx) || nx > NBW'({IW{1'b1}}))
                  && (it.read_y_bin < IW'(ny) || ny > NBW'({IW{1'b1}}));

  // Clearing pass over the store after reset.
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Saturating bin update.
  logic [SW-1:0]          rdata;
  logic signed [SW-1:0]   add;
  logic signed [SW:0]     sum_w;
  logic signed [SW-1:0]   sum;
  logic                   bin_hit;
  logic                   wr_en;
  logic [AW-1:0]          waddr;
  logic [SW-1:0]          wdata;

  assign add     = (it.cmd == h2d_pkg::CMD_FILL) ? h2d_pkg::ONE_Q16 : SW'(it.weight);
  assign sum_w   = {rdata[SW-1], rdata} + {add[SW-1], add};
  assign bin_hit = is_fill && x_ok && y_ok;

  always_comb begin
    if (sum_w > (SW+1)'(h2d_pkg::SUM_MAX)) sum = h2d_pkg::SUM_MAX;
    else if (sum_w < (SW+1)'(h2d_pkg::SUM_MIN)) sum = h2d_pkg::SUM_MIN;
    else sum = sum_w[SW-1:0];
  end

  assign wr_en = cmd.clear_wr || (cmd.finish && bin_hit);
  assign waddr = cmd.clear_wr ? clr_addr : addr;
  assign wdata = cmd.clear_wr ? '0 : sum;

  h2d_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // Out-of-range counters.
  logic [TW-1:0] xo, xu, yo, yu, xo_next, xu_next, yo_next, yu_next;

  always_comb begin
    xo_next = xo;
    xu_next = xu;
    yo_next = yo;
    yu_next = yu;
    if (is_fill) begin
      if (x_over && xo != h2d_pkg::TOT_MAX) xo_next = xo + 1'b1;
      if (x_under && xu != h2d_pkg::TOT_MAX) xu_next = xu + 1'b1;
      if (y_over && yo != h2d_pkg::TOT_MAX) yo_next = yo + 1'b1;
      if (y_under && yu != h2d_pkg::TOT_MAX) yu_next = yu + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xo <= '0;
      xu <= '0;
      yo <= '0;
      yu <= '0;
    end else if (cmd.finish) begin
      xo <= xo_next;
      xu <= xu_next;
      yo <= yo_next;
      yu <= yu_next;
    end
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.x_over_count  <= xo_next;
      result.x_under_count <= xu_next;
      result.y_over_count  <= yo_next;
      result.y_under_count <= yu_next;
      if (is_fill) begin
        result.bin_value <= bin_hit ? sum : '0;
        result.hit       <= bin_hit;
        result.x_bin     <= x_ok ? bx[IW-1:0] : '0;
        result.y_bin     <= y_ok ? by[IW-1:0] : '0;
      end else if (it.cmd == h2d_pkg::CMD_READ) begin
        result.bin_value <= rd_ok ? rdata : '0;
        result.hit       <= rd_ok;
        result.x_bin     <= it.read_x_bin;
        result.y_bin     <= it.read_y_bin;
      end else begin
        result.bin_value <= '0;
        result.hit       <= 1'b0;
        result.x_bin     <= '0;
        result.y_bin     <= '0;
      end
    end
  end

  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.div_done   = div_done;
  assign stat.fill       = is_fill;

endmodule

`default_nettype wire

[src/histogram_2d_binning_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-dimensional histogram with saturating 48-bit Q32.16 bins and four
// saturating out-of-range counters. A command is taken when start is high
// and busy is low; its result appears on result for exactly one cycle with
// done high, and must be taken then. A fill runs two 7-step divisions (one
// per axis) on a single shared restoring divider between accept and the
// result beat; a read or an unused command skips the divider. After reset a
// clearing pass writes zero to all MAX_X_BINS * MAX_Y_BINS bins, one a
// cycle, with busy high; configuration writes are taken at any time that
// busy is low, and also during that pass.
module histogram_2d_binning_unit #(
  parameter int unsigned MAX_X_BINS = 64,
  parameter int unsigned MAX_Y_BINS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire h2d_pkg::h2d_in_t           item,
  output logic                            done,
  output h2d_pkg::h2d_out_t               result,
  input  wire logic                       cfg_we,
  input  wire logic [h2d_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [h2d_pkg::VAL_W-1:0]  cfg_data
);

  h2d_pkg::h2d_cmd_t  cmd;
  h2d_pkg::h2d_stat_t stat;

  h2d_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  h2d_datapath #(
    .MAX_X_BINS (MAX_X_BINS),
    .MAX_Y_BINS (MAX_Y_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule

`default_nettype wire
